### rtl/pdsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared types, constants and the reference divider decode.
// ----------------------------------------------------------------------------
package pdsp_pkg;

  localparam int WORD_W     = 32;
  localparam int IDX_W      = 4;
  localparam int NDIV_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_DOWN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_PUMP_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_A_SELECT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_B_SELECT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INVERT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_DISABLE    = 3'd5;

  localparam logic [7:0]        REG_B_BASE   = 8'hA0;
  localparam logic [WORD_W-1:0] ERR_NONE     = 32'hFFFF_FFFF;
  localparam logic [IDX_W-1:0]  IDX_DEFAULT  = 4'd1;
  localparam logic [WORD_W-1:0] NDIV_DEFAULT = 32'd1;

  // Every reference divider is 1, 3, 5 or 15 times a power of two. The odd
  // factors are divided out by reciprocal multiplication, exact for any
  // 32-bit dividend, and the power of two by a shift.
  localparam logic [WORD_W-1:0] RECIP_3     = 32'hAAAA_AAAB;
  localparam logic [WORD_W-1:0] RECIP_5     = 32'hCCCC_CCCD;
  localparam logic [WORD_W-1:0] RECIP_15    = 32'h8888_8889;
  localparam int                RECIP_3_SH  = 33;
  localparam int                RECIP_5_SH  = 34;
  localparam int                RECIP_15_SH = 35;

  typedef struct packed {
    logic power_down;
    logic charge_pump_high;
    logic vco_a_select;
    logic vco_b_select;
    logic phase_invert;
    logic alarm_disable;
  } ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] err;
    logic              zero;
  } cand_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] err;
    logic              any;
  } best_t;

  typedef struct packed {
    logic [7:0]        subaddress_byte;
    logic [7:0]        register_a;
    logic [7:0]        register_b;
    logic [7:0]        register_c;
    logic [7:0]        register_d;
    logic [IDX_W-1:0]  reference_index;
    logic [NDIV_W-1:0] main_divider;
    logic [WORD_W-1:0] frequency_error;
    logic              divider_too_large;
    logic              no_valid_step;
  } out_item_t;

  // Channel step for table entry idx, given the reference divided by each odd
  // factor: 128, 160, 192, 240, ... 1536, 1920.
  function automatic logic [WORD_W-1:0] step_for(input logic [WORD_W-1:0] q1,
                                                 input logic [WORD_W-1:0] q3,
                                                 input logic [WORD_W-1:0] q5,
                                                 input logic [WORD_W-1:0] q15,
                                                 input logic [IDX_W-1:0]  idx);
    logic [WORD_W-1:0] r;
    case (idx)
      4'd0:    r = q1 >> 7;
      4'd1:    r = q5 >> 5;
      4'd2:    r = q3 >> 6;
      4'd3:    r = q15 >> 4;
      4'd4:    r = q1 >> 8;
      4'd5:    r = q5 >> 6;
      4'd6:    r = q3 >> 7;
      4'd7:    r = q15 >> 5;
      4'd8:    r = q1 >> 9;
      4'd9:    r = q5 >> 7;
      4'd10:   r = q3 >> 8;
      4'd11:   r = q15 >> 6;
      4'd12:   r = q1 >> 10;
      4'd13:   r = q5 >> 8;
      4'd14:   r = q3 >> 9;
      default: r = q15 >> 7;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/pdsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search channels
// Valid/ready request channels for the frequency input and the packed result.
// ----------------------------------------------------------------------------
interface pdsp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] vco_frequency;
  logic [31:0] reference_frequency;
  modport source (output valid, output vco_frequency, output reference_frequency,
                  input ready);
  modport sink (input valid, input vco_frequency, input reference_frequency,
                output ready);
endinterface

interface pdsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  subaddress_byte;
  logic [7:0]  register_a;
  logic [7:0]  register_b;
  logic [7:0]  register_c;
  logic [7:0]  register_d;
  logic [3:0]  reference_index;
  logic [17:0] main_divider;
  logic [31:0] frequency_error;
  logic        divider_too_large;
  logic        no_valid_step;
  modport source (output valid, output subaddress_byte, output register_a,
                  output register_b, output register_c, output register_d,
                  output reference_index, output main_divider, output frequency_error,
                  output divider_too_large, output no_valid_step, input ready);
  modport sink (input valid, input subaddress_byte, input register_a,
                input register_b, input register_c, input register_d,
                input reference_index, input main_divider, input frequency_error,
                input divider_too_large, input no_valid_step, output ready);
endinterface
`default_nettype wire

### rtl/pdsp_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider cell
// One quotient bit per cell; remainder and quotient share one shift word.
// ----------------------------------------------------------------------------
module pdsp_div_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [2*pdsp_pkg::WORD_W-1:0]  acc_in,
  input  logic [pdsp_pkg::WORD_W-1:0]    div_in,
  output logic [2*pdsp_pkg::WORD_W-1:0]  acc_r,
  output logic [pdsp_pkg::WORD_W-1:0]    div_r
);
  import pdsp_pkg::*;

  logic [2*WORD_W:0]   sh;
  logic [WORD_W:0]     hi;
  logic [WORD_W:0]     hi_sub;
  logic                ge;
  logic [2*WORD_W-1:0] acc_nxt;

  always_comb begin
    sh      = {acc_in, 1'b0};
    hi      = sh[2*WORD_W:WORD_W];
    ge      = (hi >= {1'b0, div_in});
    hi_sub  = ge ? (hi - {1'b0, div_in}) : hi;
    acc_nxt = {hi_sub[WORD_W-1:0], sh[WORD_W-1:1], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      div_r <= div_in;
    end
  end
endmodule
`default_nettype wire

### rtl/pdsp_min_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Best candidate cell
// Folds one candidate into the running best; the earlier candidate wins ties.
// ----------------------------------------------------------------------------
module pdsp_min_cell (
  input  logic                          clk,
  input  logic                          en,
  input  pdsp_pkg::best_t               best_in,
  input  pdsp_pkg::cand_t               cand_in,
  input  logic [pdsp_pkg::IDX_W-1:0]    cand_idx,
  output pdsp_pkg::best_t               best_r
);
  import pdsp_pkg::*;

  best_t best_nxt;

  always_comb begin
    best_nxt = best_in;
    if (!cand_in.zero) begin
      best_nxt.any = 1'b1;
      if (cand_in.err < best_in.err) begin
        best_nxt.idx = cand_idx;
        best_nxt.n   = cand_in.n;
        best_nxt.err = cand_in.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_r <= best_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/pll_divider_search_and_pack_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search and pack unit
// Picks the reference divider and main divider with the smallest frequency
// error and packs them with the control bits into the synthesizer bytes.
// ----------------------------------------------------------------------------
// Stages: one step stage, 32 main divider cells and one selection cell per choice.
// One request per cycle while the skid entry is empty; stages advance together.
// A two-entry output stage (result register plus skid) absorbs a stall; input
// ready drops only while the skid entry is occupied.
// Reset (synchronous, rst_n low) clears the pipeline, output and skid valid
// bits and the six control bits; no request is lost across a stall.
// ----------------------------------------------------------------------------
module pll_divider_search_and_pack_unit #(
  parameter int DIVIDER_CHOICES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pdsp_in_if.sink                           in_if,
  pdsp_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [pdsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdsp_pkg::*;

  localparam int LANES = DIVIDER_CHOICES;
  localparam int DEPTH = WORD_W + LANES + 1;

  // The whole pipeline advances together; it holds only while the skid
  // entry is full, so a lone waiting result never stops the next request.
  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_if.ready = en;

  // Control bits written through the configuration port.
  ctrl_t ctrl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POWER_DOWN:       ctrl_r.power_down       <= cfg_data[0];
        CFG_CHARGE_PUMP_HIGH: ctrl_r.charge_pump_high <= cfg_data[0];
        CFG_VCO_A_SELECT:     ctrl_r.vco_a_select     <= cfg_data[0];
        CFG_VCO_B_SELECT:     ctrl_r.vco_b_select     <= cfg_data[0];
        CFG_PHASE_INVERT:     ctrl_r.phase_invert     <= cfg_data[0];
        CFG_ALARM_DISABLE:    ctrl_r.alarm_disable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Valid bit for every pipeline position.
  logic [DEPTH-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_if.valid};
    end
  end

  // Step stage: the reference is divided by 3, 5 and 15 once, and each lane
  // shifts the matching quotient to get reference / R[i]. The VCO target is
  // registered alongside so both reach the main divider cells together.
  logic [2*WORD_W-1:0] prod3;
  logic [2*WORD_W-1:0] prod5;
  logic [2*WORD_W-1:0] prod15;
  logic [WORD_W-1:0]   quo3;
  logic [WORD_W-1:0]   quo5;
  logic [WORD_W-1:0]   quo15;
  logic [WORD_W-1:0]   step_r [LANES];
  logic [WORD_W-1:0]   vco_r;

  always_comb begin
    prod3  = {{WORD_W{1'b0}}, in_if.reference_frequency} * {{WORD_W{1'b0}}, RECIP_3};
    prod5  = {{WORD_W{1'b0}}, in_if.reference_frequency} * {{WORD_W{1'b0}}, RECIP_5};
    prod15 = {{WORD_W{1'b0}}, in_if.reference_frequency} * {{WORD_W{1'b0}}, RECIP_15};
    quo3   = WORD_W'(prod3 >> RECIP_3_SH);
    quo5   = WORD_W'(prod5 >> RECIP_5_SH);
    quo15  = WORD_W'(prod15 >> RECIP_15_SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vco_r <= in_if.vco_frequency;
      for (int l = 0; l < LANES; l++) begin
        step_r[l] <= step_for(in_if.reference_frequency, quo3, quo5, quo15, IDX_W'(l));
      end
    end
  end

  // Each lane's divider row forms the main divider and its remainder,
  // vco / step. The remainder is the error.
  logic [2*WORD_W-1:0] b_acc_in [LANES][WORD_W];
  logic [WORD_W-1:0]   b_div_in [LANES][WORD_W];
  logic [2*WORD_W-1:0] b_acc    [LANES][WORD_W];
  logic [WORD_W-1:0]   b_div    [LANES][WORD_W];
  cand_t               cand_src [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar k = 0; k < WORD_W; k++) begin : g_bit
      if (k == 0) begin : g_first
        assign b_acc_in[l][k] = {{WORD_W{1'b0}}, vco_r};
        assign b_div_in[l][k] = step_r[l];
      end else begin : g_next
        assign b_acc_in[l][k] = b_acc[l][k-1];
        assign b_div_in[l][k] = b_div[l][k-1];
      end

      pdsp_div_cell u_ndiv_cell (
        .clk    (clk),
        .en     (en),
        .acc_in (b_acc_in[l][k]),
        .div_in (b_div_in[l][k]),
        .acc_r  (b_acc[l][k]),
        .div_r  (b_div[l][k])
      );
    end

    assign cand_src[l].n    = b_acc[l][WORD_W-1][WORD_W-1:0];
    assign cand_src[l].err  = b_acc[l][WORD_W-1][2*WORD_W-1:WORD_W];
    assign cand_src[l].zero = (b_div[l][WORD_W-1] == '0);
  end

  // Selection row: cell s folds candidate s into the running best while the
  // candidate set travels alongside it.
  cand_t cand_in [LANES][LANES];
  cand_t cand_r  [LANES][LANES];
  best_t best_in [LANES];
  best_t best_q  [LANES];

  for (genvar s = 0; s < LANES; s++) begin : g_sel
    for (genvar l = 0; l < LANES; l++) begin : g_c
      if (s == 0) begin : g_first
        assign cand_in[s][l] = cand_src[l];
      end else begin : g_next
        assign cand_in[s][l] = cand_r[s-1][l];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          cand_r[s][l] <= cand_in[s][l];
        end
      end
    end

    if (s == 0) begin : g_init
      assign best_in[s] = '{idx: IDX_DEFAULT, n: NDIV_DEFAULT, err: ERR_NONE, any: 1'b0};
    end else begin : g_chain
      assign best_in[s] = best_q[s-1];
    end

    pdsp_min_cell u_min_cell (
      .clk      (clk),
      .en       (en),
      .best_in  (best_in[s]),
      .cand_in  (cand_in[s][s]),
      .cand_idx (IDX_W'(s)),
      .best_r   (best_q[s])
    );
  end

  // Packing of the chosen setting into the synthesizer bytes.
  best_t             best_fin;
  logic [NDIV_W-1:0] n18;
  out_item_t         pack_item;
  logic              pack_v;

  assign best_fin = best_q[LANES-1];
  assign n18      = best_fin.n[NDIV_W-1:0];
  assign pack_v   = vld_r[DEPTH-1] & en;

  always_comb begin
    pack_item.subaddress_byte   = {3'b000, ctrl_r.alarm_disable, 1'b1, 3'b000};
    pack_item.register_a        = {ctrl_r.power_down, 1'b0, ctrl_r.charge_pump_high, 1'b0,
                                   best_fin.idx};
    pack_item.register_b        = REG_B_BASE | {3'b000, ctrl_r.phase_invert,
                                   ctrl_r.vco_b_select, ctrl_r.vco_a_select, n18[17:16]};
    pack_item.register_c        = n18[15:8];
    pack_item.register_d        = n18[7:0];
    pack_item.reference_index   = best_fin.idx;
    pack_item.main_divider      = n18;
    pack_item.frequency_error   = best_fin.err;
    pack_item.divider_too_large = |best_fin.n[WORD_W-1:NDIV_W];
    pack_item.no_valid_step     = !best_fin.any;
  end

  // Output register and skid entry.
  out_item_t out_item_r;
  out_item_t skid_item_r;
  logic      out_v_r;
  logic      take;

  assign take = out_if.ready || !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      out_v_r  <= skid_v_r || pack_v;
      skid_v_r <= 1'b0;
    end else if (pack_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= skid_v_r ? skid_item_r : pack_item;
    end else if (pack_v) begin
      skid_item_r <= pack_item;
    end
  end

  assign out_if.valid             = out_v_r;
  assign out_if.subaddress_byte   = out_item_r.subaddress_byte;
  assign out_if.register_a        = out_item_r.register_a;
  assign out_if.register_b        = out_item_r.register_b;
  assign out_if.register_c        = out_item_r.register_c;
  assign out_if.register_d        = out_item_r.register_d;
  assign out_if.reference_index   = out_item_r.reference_index;
  assign out_if.main_divider      = out_item_r.main_divider;
  assign out_if.frequency_error   = out_item_r.frequency_error;
  assign out_if.divider_too_large = out_item_r.divider_too_large;
  assign out_if.no_valid_step     = out_item_r.no_valid_step;
endmodule
`default_nettype wire

### rtl/pdsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pdsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  subaddress_byte,
  input logic [7:0]  register_a,
  input logic [7:0]  register_b,
  input logic [7:0]  register_c,
  input logic [7:0]  register_d,
  input logic [3:0]  reference_index,
  input logic [17:0] main_divider,
  input logic [31:0] frequency_error,
  input logic        no_valid_step
);
  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // With no usable step the fallback setting is reported.
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_valid_step |->
      frequency_error == 32'hFFFF_FFFF && reference_index == 4'd1 && main_divider == 18'd1)
    else $error("fallback setting not reported");

  // The divider bytes carry the reported main divider.
  a_div_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> register_c == main_divider[15:8] && register_d == main_divider[7:0]
                  && register_b[1:0] == main_divider[17:16])
    else $error("divider bytes disagree with main divider");

  // Fixed bits of the packed bytes and the reference index field.
  a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> register_b[7:5] == 3'b101 && subaddress_byte[3] == 1'b1
                  && register_a[3:0] == reference_index && register_a[6] == 1'b0)
    else $error("fixed byte bits or index field wrong");
endmodule

bind pll_divider_search_and_pack_unit pdsp_checker u_pdsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .subaddress_byte (out_if.subaddress_byte),
  .register_a      (out_if.register_a),
  .register_b      (out_if.register_b),
  .register_c      (out_if.register_c),
  .register_d      (out_if.register_d),
  .reference_index (out_if.reference_index),
  .main_divider    (out_if.main_divider),
  .frequency_error (out_if.frequency_error),
  .no_valid_step   (out_if.no_valid_step)
);
`default_nettype wire

### tb/tb_pll_divider_search_and_pack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search and pack unit testbench
// Sends frequency requests with random gaps and output stalls, predicts the
// best reference/main divider pair and the packed bytes for each request, and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pll_divider_search_and_pack_unit;
  import pdsp_pkg::*;

  localparam int CHOICES     = 16;
  localparam int LATENCY     = 33 + CHOICES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pdsp_in_if  in_if ();
  pdsp_out_if out_if ();

  pll_divider_search_and_pack_unit #(.DIVIDER_CHOICES(CHOICES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if.sink),
    .out_if   (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Our own copy of the six control bits, updated on every register write.
  ctrl_t     ctrl_shadow;
  out_item_t pending_settings[$];
  int        mismatches;
  int        results_seen;
  int        requests_sent;
  int        cycle_count;
  bit        sender_no_gaps;
  bit        receiver_no_stall;
  bit        hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hardware-divider table, kept separately from the package copy.
  function automatic bit [31:0] divider_of(int i);
    bit [31:0] divs [16] = '{128, 160, 192, 240, 256, 320, 384, 480,
                             512, 640, 768, 960, 1024, 1280, 1536, 1920};
    return divs[i];
  endfunction

  // Search every reference divider for the smallest frequency error, keeping
  // the earliest on a tie, then pack the chosen setting into the bytes.
  function automatic out_item_t predict_setting(bit [31:0] vco, bit [31:0] refclk,
                                                ctrl_t c);
    out_item_t r;
    bit [3:0]  best_idx;
    bit [31:0] best_n;
    bit [31:0] best_err;
    bit        found;
    bit [31:0] step;
    bit [31:0] n;
    bit [31:0] err;
    bit [17:0] n18;
    best_idx = 4'd1;
    best_n   = 32'd1;
    best_err = 32'hFFFF_FFFF;
    found    = 1'b0;
    for (int i = 0; i < CHOICES; i++) begin
      step = refclk / divider_of(i);
      if (step != 0) begin
        found = 1'b1;
        n     = vco / step;
        err   = vco - n * step;
        if (err < best_err) begin
          best_idx = i[3:0];
          best_n   = n;
          best_err = err;
        end
      end
    end
    n18 = best_n[17:0];
    r.subaddress_byte   = {3'b000, c.alarm_disable, 4'b1000};
    r.register_a        = {c.power_down, 1'b0, c.charge_pump_high, 1'b0, best_idx};
    r.register_b        = {3'b101, c.phase_invert, c.vco_b_select, c.vco_a_select,
                           n18[17:16]};
    r.register_c        = n18[15:8];
    r.register_d        = n18[7:0];
    r.reference_index   = best_idx;
    r.main_divider      = n18;
    r.frequency_error   = best_err;
    r.divider_too_large = (best_n > 32'h3FFFF);
    r.no_valid_step     = !found;
    return r;
  endfunction

  task automatic check_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_v, act_v);
    end
  endtask

  // Record predictions when a request is taken and check results when they
  // leave. Both handshakes are sampled right at the rising edge.
  always @(posedge clk) begin
    out_item_t exp_s;
    if (rst_n && in_if.valid && in_if.ready) begin
      pending_settings.push_back(predict_setting(in_if.vco_frequency,
                                                 in_if.reference_frequency,
                                                 ctrl_shadow));
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_settings.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no request outstanding", $time);
      end else begin
        exp_s = pending_settings.pop_front();
        check_field("subaddress_byte", exp_s.subaddress_byte, out_if.subaddress_byte);
        check_field("register_a", exp_s.register_a, out_if.register_a);
        check_field("register_b", exp_s.register_b, out_if.register_b);
        check_field("register_c", exp_s.register_c, out_if.register_c);
        check_field("register_d", exp_s.register_d, out_if.register_d);
        check_field("reference_index", exp_s.reference_index, out_if.reference_index);
        check_field("main_divider", exp_s.main_divider, out_if.main_divider);
        check_field("frequency_error", exp_s.frequency_error, out_if.frequency_error);
        check_field("divider_too_large", exp_s.divider_too_large,
                    out_if.divider_too_large);
        check_field("no_valid_step", exp_s.no_valid_step, out_if.no_valid_step);
      end
    end
  end

  // Result side: random stalls, a stall-free mode, and a long counted hold-off
  // so the pipeline fills and the input side has to back off.
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else if (receiver_no_stall) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = ($urandom_range(99) >= 34);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d predictions outstanding",
                 cycle_count, pending_settings.size());
        $display("FAIL pll_divider_search_and_pack_unit");
        $finish;
      end
    end
  end

  // Offers one request, with a random gap first unless gaps are off, and
  // returns once it has been taken, then clears valid.
  task automatic send_request(bit [31:0] vco, bit [31:0] refclk);
    if (!sender_no_gaps) begin
      while ($urandom_range(99) < 34) begin
        in_if.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_if.valid               = 1'b1;
    in_if.vco_frequency       = vco;
    in_if.reference_frequency = refclk;
    do @(posedge clk); while (!in_if.ready);
    requests_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, bit value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_POWER_DOWN:       ctrl_shadow.power_down       = value;
      CFG_CHARGE_PUMP_HIGH: ctrl_shadow.charge_pump_high = value;
      CFG_VCO_A_SELECT:     ctrl_shadow.vco_a_select     = value;
      CFG_VCO_B_SELECT:     ctrl_shadow.vco_b_select     = value;
      CFG_PHASE_INVERT:     ctrl_shadow.phase_invert     = value;
      CFG_ALARM_DISABLE:    ctrl_shadow.alarm_disable    = value;
      default: ;
    endcase
  endtask

  task automatic set_all_controls(ctrl_t c);
    write_register(CFG_POWER_DOWN, c.power_down);
    write_register(CFG_CHARGE_PUMP_HIGH, c.charge_pump_high);
    write_register(CFG_VCO_A_SELECT, c.vco_a_select);
    write_register(CFG_VCO_B_SELECT, c.vco_b_select);
    write_register(CFG_PHASE_INVERT, c.phase_invert);
    write_register(CFG_ALARM_DISABLE, c.alarm_disable);
  endtask

  // Waits until every predicted result has come back, then lets the pipeline
  // settle before the registers change.
  task automatic wait_until_idle();
    while (pending_settings.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
  endtask

  // Edge cases: zero inputs, references too low for any divider, only the
  // first divider usable, an oversized main divider, ties and full scale.
  task automatic test_corner_frequencies();
    send_request(32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'd127);
    send_request(32'd1000, 32'd128);
    send_request(32'hFFFF_FFFF, 32'd128);
    send_request(32'hFFFF_FFFF, 32'd1919);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd1, 32'hFFFF_FFFF);
    send_request(32'd3_840_000, 32'd1_920_000);
    send_request(32'd1_000_000_000, 32'd10_000_000);
    send_request(32'd433_920_000, 32'd12_800_000);
    send_request(32'h8000_0000, 32'h0000_0300);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'd262_143, 32'd128);
    send_request(32'd262_144, 32'd128);
  endtask

  // A write to an index past the last register must change nothing.
  task automatic test_unused_register_index();
    write_register(3'd6, 1'b1);
    write_register(3'd7, 1'b1);
    send_request(32'd868_000_000, 32'd26_000_000);
    send_request(32'd0, 32'd100);
  endtask

  task automatic test_random_requests(int count);
    bit [31:0] vco;
    bit [31:0] refclk;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1: begin
          vco    = $urandom;
          refclk = $urandom;
        end
        2: begin
          refclk = $urandom_range(4000);
          vco    = $urandom_range(400_000);
        end
        3: begin
          refclk = $urandom_range(4000);
          vco    = $urandom;
        end
        default: begin
          refclk = $urandom_range(50_000_000, 1_000_000);
          vco    = $urandom_range(2_000_000_000, 50_000_000);
        end
      endcase
      send_request(vco, refclk);
    end
  endtask

  // Long output hold-off while requests keep coming: the block must fill,
  // drop its input ready and lose nothing.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    sender_no_gaps = 1'b1;
    test_random_requests(120);
    sender_no_gaps = 1'b0;
  endtask

  task automatic test_back_to_back();
    sender_no_gaps    = 1'b1;
    receiver_no_stall = 1'b1;
    test_random_requests(60);
    sender_no_gaps    = 1'b0;
    receiver_no_stall = 1'b0;
  endtask

  initial begin
    mismatches        = 0;
    results_seen      = 0;
    requests_sent     = 0;
    sender_no_gaps    = 1'b0;
    receiver_no_stall = 1'b0;
    hold_request      = 1'b0;
    ctrl_shadow       = '0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_if.valid               = 1'b0;
    in_if.vco_frequency       = '0;
    in_if.reference_frequency = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset values of the control bits first.
    test_corner_frequencies();
    wait_until_idle();

    set_all_controls(6'b111111);
    test_corner_frequencies();
    wait_until_idle();
    test_unused_register_index();
    wait_until_idle();

    set_all_controls(6'b101010);
    test_random_requests(90);
    wait_until_idle();

    set_all_controls(6'b010101);
    test_output_backpressure();
    wait_until_idle();

    set_all_controls(6'b000000);
    test_back_to_back();
    wait_until_idle();

    for (int p = 0; p < 2; p++) begin
      set_all_controls(ctrl_t'($urandom_range(63)));
      test_random_requests(70);
      wait_until_idle();
    end

    $display("Covered %0d requests and %0d results over %0d cycles,", requests_sent,
             results_seen, cycle_count);
    $display("with corner frequencies, six control settings and a long output stall.");
    if (mismatches == 0) begin
      $display("PASS pll_divider_search_and_pack_unit");
    end else begin
      $display("FAIL pll_divider_search_and_pack_unit");
    end
    $finish;
  end

endmodule

### pll_divider_search_and_pack_unit.f
rtl/pdsp_pkg.sv
rtl/pdsp_if.sv
rtl/pdsp_div_cell.sv
rtl/pdsp_min_cell.sv
rtl/pll_divider_search_and_pack_unit.sv
rtl/pdsp_checker.sv
tb/tb_pll_divider_search_and_pack_unit.sv
